// ===== design/bvpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bvpd_pkg: shared definitions for the bitmap pixel decoder
// Widths, display mode codes, operation codes, register indexes and the
// stage payload type passed from the palette read stage to the decoder.
// ----------------------------------------------------------------------------
package bvpd_pkg;

    localparam int PIX_W     = 32;
    localparam int IDX_W     = 4;
    localparam int PAL_DEPTH = 16;
    localparam int NUM_PIX   = 4;
    localparam int CNT_W     = 3;
    localparam int MODE_W    = 3;
    localparam int C0_W      = 5;
    localparam int CFG_IDX_W = 1;

    // display modes (code 7 decodes as gray)
    localparam logic [MODE_W-1:0] MODE_4BPP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_2BPP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_4BPP_2B = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RGB332  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_YJK_PAL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_YJK     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_GRAY    = 3'd6;

    // operations
    localparam logic OP_PAL_WR = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR0 = 1'd1;

    localparam logic [C0_W-1:0]  COLOR0_RESET = 5'd16;
    localparam logic [PIX_W-1:0] GRAY_PIXEL   = 32'hFF80_8080;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

    localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_FOUR = 3'd4;

    typedef logic [NUM_PIX-1:0][PIX_W-1:0] t_pix_vec;
    typedef logic [NUM_PIX-1:0][IDX_W-1:0] t_idx_vec;
    typedef logic [NUM_PIX-1:0][7:0]       t_byte_vec;

    // payload held in the palette read stage
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_byte_vec         bytes;
    } t_dec_in;

endpackage

// ===== design/bvpd_palette.sv =====
// ----------------------------------------------------------------------------
// bvpd_palette: 16-entry color table with one read lane per pixel
// One write port and four registered reads per cycle, so the four lookups
// of an item are registered at the same edge that takes it.
// ----------------------------------------------------------------------------
module bvpd_palette (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [bvpd_pkg::IDX_W-1:0]           i_waddr,
    input  logic [bvpd_pkg::PIX_W-1:0]           i_wdata,
    input  logic                                 i_re,
    input  bvpd_pkg::t_idx_vec                   i_raddr,
    output bvpd_pkg::t_pix_vec                   o_rdata
);

    logic [bvpd_pkg::PIX_W-1:0] r_mem [bvpd_pkg::PAL_DEPTH];
    bvpd_pkg::t_pix_vec         r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, one address per lane
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            for (int c = 0; c < bvpd_pkg::NUM_PIX; c++) begin
                r_rdata[c] <= r_mem[i_raddr[c]];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bvpd_decode.sv =====
// ----------------------------------------------------------------------------
// bvpd_decode: per-mode pixel formation
// Combines palette read data with direct RGB 3-3-2 and YJK conversion, or
// fills gray, and yields four RGBA pixels plus the pixel count.
// ----------------------------------------------------------------------------
module bvpd_decode (
    input  bvpd_pkg::t_dec_in              i_dec,
    input  bvpd_pkg::t_pix_vec             i_pal,
    output bvpd_pkg::t_pix_vec             o_pix,
    output logic [bvpd_pkg::CNT_W-1:0]     o_count
);

    // RGB 3-3-2 expansion: green 7..5, red 4..2, blue 1..0
    function automatic logic [31:0] rgb332(input logic [7:0] v);
        logic [2:0] r;
        logic [2:0] g;
        logic [1:0] b;
        r = v[4:2];
        g = v[7:5];
        b = v[1:0];
        return {bvpd_pkg::ALPHA_OPAQUE, {b, b, b, b}, {g, g, g[2:1]}, {r, r, r[2:1]}};
    endfunction

    // clamp an 8-bit two's complement value to 0..31
    function automatic logic [4:0] clamp8(input logic [7:0] v);
        logic [4:0] c;
        if (v[7]) c = 5'd0;
        else if (|v[6:5]) c = 5'd31;
        else c = v[4:0];
        return c;
    endfunction

    // one YJK pixel; j and k are 6-bit two's complement
    function automatic logic [31:0] yjk_pixel(input logic [7:0] p, input logic [5:0] j,
                                              input logic [5:0] k);
        logic [9:0] y10;
        logic [9:0] num;
        logic [7:0] rs;
        logic [7:0] gs;
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        y10 = {5'd0, p[7:3]};
        rs  = {3'd0, p[7:3]} + {{2{j[5]}}, j};
        gs  = {3'd0, p[7:3]} + {{2{k[5]}}, k};
        num = (y10 << 2) + y10 - ({{4{j[5]}}, j} << 1) - {{4{k[5]}}, k} + 10'd2;
        r = clamp8(rs);
        g = clamp8(gs);
        // negative numerators truncate to zero or below: both clamp to 0
        if (num[9]) b = 5'd0;
        else if (|num[8:7]) b = 5'd31;
        else b = num[6:2];
        return {bvpd_pkg::ALPHA_OPAQUE, {b, b[4:2]}, {g, g[4:2]}, {r, r[4:2]}};
    endfunction

    logic [5:0] w_k;
    logic [5:0] w_j;

    assign w_k = {i_dec.bytes[1][2:0], i_dec.bytes[0][2:0]};
    assign w_j = {i_dec.bytes[3][2:0], i_dec.bytes[2][2:0]};

    // mode select
    always_comb begin
        o_pix   = '0;
        o_count = bvpd_pkg::CNT_FOUR;
        unique case (i_dec.mode)
            bvpd_pkg::MODE_4BPP: begin
                o_pix[0] = i_pal[0];
                o_pix[1] = i_pal[1];
                o_count  = bvpd_pkg::CNT_TWO;
            end
            bvpd_pkg::MODE_2BPP, bvpd_pkg::MODE_4BPP_2B: begin
                o_pix = i_pal;
            end
            bvpd_pkg::MODE_RGB332: begin
                o_pix[0] = rgb332(i_dec.bytes[0]);
                o_pix[1] = rgb332(i_dec.bytes[1]);
                o_count  = bvpd_pkg::CNT_TWO;
            end
            bvpd_pkg::MODE_YJK_PAL: begin
                for (int n = 0; n < bvpd_pkg::NUM_PIX; n++) begin
                    o_pix[n] = i_dec.bytes[n][3] ? i_pal[n]
                                                 : yjk_pixel(i_dec.bytes[n], w_j, w_k);
                end
            end
            bvpd_pkg::MODE_YJK: begin
                for (int n = 0; n < bvpd_pkg::NUM_PIX; n++) begin
                    o_pix[n] = yjk_pixel(i_dec.bytes[n], w_j, w_k);
                end
            end
            default: begin
                for (int n = 0; n < bvpd_pkg::NUM_PIX; n++) begin
                    o_pix[n] = bvpd_pkg::GRAY_PIXEL;
                end
            end
        endcase
    end

endmodule

// ===== design/bitmap_vram_pixel_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_vram_pixel_decoder_unit: bitmap video-memory pixel decoder
// Turns byte groups into packed RGBA pixels under the selected display mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): operation 0 stores palette entry
//   i_palette_index with i_palette_color and gives no result; operation 1
//   carries four bytes and gives one result of two or four pixels.
//   Output channel (o_out_valid / i_out_stall): pixels 0..3 and the count;
//   unused pixel fields read zero.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
//   display mode, index 1 the color-0 source. Write only while idle.
//   Flow: a data item is taken into the palette read stage, then decoded
//   into the result register, from which it is shown. One item per cycle
//   is sustained while the output is not stalled: the palette gives four
//   registered reads each cycle and the decode is one short logic pass.
//   Stall: a held result holds the read stage behind it; the input stalls
//   only when both stages are full and the output is stalled.
//   Reset: clears the pipeline valids, mode 0, no color-0 substitution.
//   Palette contents are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module bitmap_vram_pixel_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [bvpd_pkg::IDX_W-1:0]          i_palette_index,
    input  logic [bvpd_pkg::PIX_W-1:0]          i_palette_color,
    input  logic [7:0]                          i_byte0,
    input  logic [7:0]                          i_byte1,
    input  logic [7:0]                          i_byte2,
    input  logic [7:0]                          i_byte3,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bvpd_pkg::PIX_W-1:0]          o_pixel0,
    output logic [bvpd_pkg::PIX_W-1:0]          o_pixel1,
    output logic [bvpd_pkg::PIX_W-1:0]          o_pixel2,
    output logic [bvpd_pkg::PIX_W-1:0]          o_pixel3,
    output logic [bvpd_pkg::CNT_W-1:0]          o_pixel_count,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bvpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bvpd_pkg::C0_W-1:0]           i_cfg_data
);

    logic [bvpd_pkg::MODE_W-1:0] r_mode;
    logic [bvpd_pkg::C0_W-1:0]   r_color0;
    logic                        r_s1_vld;
    bvpd_pkg::t_dec_in           r_s1;
    logic                        r_out_vld;
    bvpd_pkg::t_pix_vec          r_out_pix;
    logic [bvpd_pkg::CNT_W-1:0]  r_out_cnt;

    logic                        w_in_xfer;
    logic                        w_pix_xfer;
    logic                        w_pal_we;
    logic                        w_out_free;
    logic                        w_s1_adv;
    bvpd_pkg::t_byte_vec         w_bytes;
    bvpd_pkg::t_idx_vec          w_idx;
    bvpd_pkg::t_idx_vec          w_raddr;
    bvpd_pkg::t_pix_vec          w_pal;
    bvpd_pkg::t_pix_vec          w_pix;
    logic [bvpd_pkg::CNT_W-1:0]  w_cnt;

    // handshake
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_s1_adv   = r_s1_vld && w_out_free;
    assign o_in_stall = r_s1_vld && !w_out_free;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_pix_xfer = w_in_xfer && (i_operation == bvpd_pkg::OP_PIXEL);
    assign w_pal_we   = w_in_xfer && (i_operation == bvpd_pkg::OP_PAL_WR);
    assign o_cfg_ready = 1'b1;

    assign w_bytes = {i_byte3, i_byte2, i_byte1, i_byte0};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= bvpd_pkg::MODE_4BPP;
            r_color0 <= bvpd_pkg::COLOR0_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bvpd_pkg::CFG_MODE:   r_mode   <= i_cfg_data[bvpd_pkg::MODE_W-1:0];
                bvpd_pkg::CFG_COLOR0: r_color0 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // palette index per lane for the current mode
    always_comb begin
        w_idx = '0;
        unique case (r_mode)
            bvpd_pkg::MODE_4BPP, bvpd_pkg::MODE_4BPP_2B: begin
                w_idx[0] = w_bytes[0][7:4];
                w_idx[1] = w_bytes[0][3:0];
                w_idx[2] = w_bytes[1][7:4];
                w_idx[3] = w_bytes[1][3:0];
            end
            bvpd_pkg::MODE_2BPP: begin
                w_idx[0] = {2'b00, w_bytes[0][7:6]};
                w_idx[1] = {2'b00, w_bytes[0][5:4]};
                w_idx[2] = {2'b00, w_bytes[0][3:2]};
                w_idx[3] = {2'b00, w_bytes[0][1:0]};
            end
            bvpd_pkg::MODE_YJK_PAL: begin
                for (int n = 0; n < bvpd_pkg::NUM_PIX; n++) begin
                    w_idx[n] = w_bytes[n][7:4];
                end
            end
            default: w_idx = '0;
        endcase
    end

    // color-0 substitution; source 16 and above means none
    always_comb begin
        for (int n = 0; n < bvpd_pkg::NUM_PIX; n++) begin
            if (w_idx[n] == '0 && !r_color0[bvpd_pkg::C0_W-1]) begin
                w_raddr[n] = r_color0[bvpd_pkg::IDX_W-1:0];
            end else begin
                w_raddr[n] = w_idx[n];
            end
        end
    end

    bvpd_palette u_palette (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (i_palette_index),
        .i_wdata (i_palette_color),
        .i_re    (w_pix_xfer),
        .i_raddr (w_raddr),
        .o_rdata (w_pal)
    );

    // palette read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_pix_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pix_xfer) begin
            r_s1.mode  <= r_mode;
            r_s1.bytes <= w_bytes;
        end
    end

    bvpd_decode u_decode (
        .i_dec   (r_s1),
        .i_pal   (w_pal),
        .o_pix   (w_pix),
        .o_count (w_cnt)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_pix <= w_pix;
            r_out_cnt <= w_cnt;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_pixel0      = r_out_pix[0];
    assign o_pixel1      = r_out_pix[1];
    assign o_pixel2      = r_out_pix[2];
    assign o_pixel3      = r_out_pix[3];
    assign o_pixel_count = r_out_cnt;

`ifndef SYNTHESIS
    // a data transfer always lands in the read stage
    a_pix_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pix_xfer |=> r_s1_vld)
        else $error("data transfer lost before read stage");

    // the input only stalls behind a full, blocked read stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_vld && r_out_vld && i_out_stall))
        else $error("input stalled without backpressure");

    // a blocked read stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_out_free) |=> (r_s1_vld && $stable(r_s1)))
        else $error("read stage item changed while blocked");

    // results count two or four pixels; two-pixel results carry zero in the unused lanes
    a_count_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pixel_count == bvpd_pkg::CNT_FOUR) ||
                         (o_pixel_count == bvpd_pkg::CNT_TWO && o_pixel2 == '0 &&
                          o_pixel3 == '0)))
        else $error("bad pixel count or unused lanes not zero");
`endif

endmodule
